[hdl/epwf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package epwf_pkg;

  localparam int QueueDepth = 4;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_DATA  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_NODATA  = 2'd2;

  localparam logic REG_DEVICE_TYPE = 1'b0;
  localparam logic REG_BASE_ADDR   = 1'b1;

  localparam logic [3:0] TYPE_LAST  = 4'd9;
  localparam logic [3:0] TYPE_RESET = 4'd1;
  localparam logic [6:0] BASE_RESET = 7'd80;

  typedef enum logic [2:0] {
    KIND_WSTART = 3'd0,
    KIND_ADDR   = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_STOP   = 3'd3,
    KIND_RSTART = 3'd4,
    KIND_STATUS = 3'd5
  } tok_kind_t;

  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_READ   = 2'd1,
    CMD_DATA   = 2'd2
  } cmd_op_t;

  typedef enum logic [2:0] {
    STEP_WSTART = 3'd0,
    STEP_AHI    = 3'd1,
    STEP_ALO    = 3'd2,
    STEP_BODY   = 3'd3,
    STEP_STOP   = 3'd4
  } step_t;

  typedef struct packed {
    cmd_op_t     op;
    step_t       first_step;
    logic        stop;
    logic        two_byte;
    logic [6:0]  dev;
    logic [6:0]  base;
    logic [15:0] mem;
    logic [15:0] count;
    logic [7:0]  data;
    logic [1:0]  status;
  } cmd_t;

  function automatic logic [16:0] part_cap(input logic [3:0] t);
    logic [16:0] c;
    case (t)
      4'd0: c = 17'd128;
      4'd1: c = 17'd256;
      4'd2: c = 17'd512;
      4'd3: c = 17'd1024;
      4'd4: c = 17'd2048;
      4'd5: c = 17'd4096;
      4'd6: c = 17'd8192;
      4'd7: c = 17'd16384;
      4'd8: c = 17'd32768;
      default: c = 17'd65536;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] page_mask(input logic [3:0] t);
    logic [6:0] m;
    case (t)
      4'd0, 4'd1: m = 7'd7;
      4'd2, 4'd3, 4'd4: m = 7'd15;
      4'd5, 4'd6: m = 7'd31;
      4'd7, 4'd8: m = 7'd63;
      default: m = 7'd127;
    endcase
    return m;
  endfunction

  function automatic logic two_addr_bytes(input logic [3:0] t);
    return (t > 4'd4);
  endfunction

  function automatic logic [6:0] i2c_addr(input logic [3:0] t, input logic [6:0] base,
                                         input logic [15:0] mem);
    logic [6:0] d;
    case (t)
      4'd2: d = {base[6:1], mem[8]};
      4'd3: d = {base[6:2], mem[9:8]};
      4'd4: d = {base[6:3], mem[10:8]};
      default: d = base;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

[hdl/epwf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module epwf_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [6:0]          cfg_wdata,
  input  wire logic                accept,
  input  wire logic [1:0]          func,
  input  wire logic [15:0]         start_address,
  input  wire logic [15:0]         length,
  input  wire logic [7:0]          data_byte,
  output logic                     push,
  output epwf_pkg::cmd_t           cmd
);

  logic [3:0]  device_type_r, device_type_nxt;
  logic [6:0]  base_addr_r, base_addr_nxt;
  logic [15:0] cur_addr_r, cur_addr_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic        write_active_r, write_active_nxt;
  logic        chunk_open_r, chunk_open_nxt;

  logic [3:0]  tsel;
  logic [16:0] span;
  logic [15:0] addr_inc;
  logic [15:0] rem_dec;
  logic        stop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_type_r  <= epwf_pkg::TYPE_RESET;
      base_addr_r    <= epwf_pkg::BASE_RESET;
      cur_addr_r     <= '0;
      remaining_r    <= '0;
      write_active_r <= 1'b0;
      chunk_open_r   <= 1'b0;
    end else begin
      device_type_r  <= device_type_nxt;
      base_addr_r    <= base_addr_nxt;
      cur_addr_r     <= cur_addr_nxt;
      remaining_r    <= remaining_nxt;
      write_active_r <= write_active_nxt;
      chunk_open_r   <= chunk_open_nxt;
    end
  end

  always_comb begin
    device_type_nxt = device_type_r;
    base_addr_nxt   = base_addr_r;
    if (cfg_we) begin
      case (cfg_index)
        epwf_pkg::REG_DEVICE_TYPE: device_type_nxt = cfg_wdata[3:0];
        epwf_pkg::REG_BASE_ADDR:   base_addr_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    tsel     = (device_type_r > epwf_pkg::TYPE_LAST) ? epwf_pkg::TYPE_LAST : device_type_r;
    span     = {1'b0, start_address} + {1'b0, length};
    addr_inc = cur_addr_r + 16'd1;
    rem_dec  = remaining_r - 16'd1;
    stop     = (rem_dec == 16'd0) || ((addr_inc[6:0] & epwf_pkg::page_mask(tsel)) == 7'd0);

    cur_addr_nxt     = cur_addr_r;
    remaining_nxt    = remaining_r;
    write_active_nxt = write_active_r;
    chunk_open_nxt   = chunk_open_r;
    push             = 1'b0;

    cmd            = '0;
    cmd.op         = epwf_pkg::CMD_STATUS;
    cmd.first_step = epwf_pkg::STEP_BODY;
    cmd.two_byte   = epwf_pkg::two_addr_bytes(tsel);
    cmd.base       = base_addr_r;
    cmd.data       = data_byte;
    cmd.count      = length;
    cmd.mem        = start_address;
    cmd.dev        = epwf_pkg::i2c_addr(tsel, base_addr_r, start_address);
    cmd.status     = epwf_pkg::STAT_OK;

    case (func)
      epwf_pkg::FUNC_WRITE, epwf_pkg::FUNC_READ: begin
        push             = accept;
        write_active_nxt = 1'b0;
        chunk_open_nxt   = 1'b0;
        if (length == 16'd0) begin
          cmd.status = epwf_pkg::STAT_OK;
        end else if (span > epwf_pkg::part_cap(tsel)) begin
          cmd.status = epwf_pkg::STAT_RANGE;
        end else if (func == epwf_pkg::FUNC_WRITE) begin
          cur_addr_nxt     = start_address;
          remaining_nxt    = length;
          write_active_nxt = 1'b1;
        end else begin
          cmd.op         = epwf_pkg::CMD_READ;
          cmd.first_step = epwf_pkg::STEP_WSTART;
        end
      end
      epwf_pkg::FUNC_DATA: begin
        push = accept;
        if (!write_active_r) begin
          cmd.status = epwf_pkg::STAT_NODATA;
        end else begin
          cmd.op         = epwf_pkg::CMD_DATA;
          cmd.first_step = chunk_open_r ? epwf_pkg::STEP_BODY : epwf_pkg::STEP_WSTART;
          cmd.mem        = cur_addr_r;
          cmd.dev        = epwf_pkg::i2c_addr(tsel, base_addr_r, cur_addr_r);
          cmd.stop       = stop;
          cur_addr_nxt     = addr_inc;
          remaining_nxt    = rem_dec;
          chunk_open_nxt   = !stop;
          write_active_nxt = (rem_dec != 16'd0);
        end
      end
      default: ;
    endcase

    if (!accept) begin
      cur_addr_nxt     = cur_addr_r;
      remaining_nxt    = remaining_r;
      write_active_nxt = write_active_r;
      chunk_open_nxt   = chunk_open_r;
    end
  end

endmodule
`default_nettype wire

[hdl/epwf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module epwf_queue #(
  parameter int DEPTH = epwf_pkg::QueueDepth
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire epwf_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output epwf_pkg::cmd_t      head,
  output logic                empty,
  output logic                full
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  epwf_pkg::cmd_t entries_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  always_comb begin
    empty   = (count_r == '0);
    full    = (count_r == CntFull);
    do_push = push && !full;
    do_pop  = pop && !empty;
    head    = entries_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CntW'(1);
      2'b01:   count_nxt = count_r - CntW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

[hdl/epwf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module epwf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire epwf_pkg::cmd_t head,
  input  wire logic           empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [2:0]          out_token_kind,
  output logic [7:0]          out_token_value,
  output logic [15:0]         out_read_count,
  output logic [1:0]          out_status,
  output logic                out_last
);

  epwf_pkg::step_t     step_r, step_nxt;
  logic                mid_r, mid_nxt;
  logic                valid_r, valid_nxt;
  epwf_pkg::tok_kind_t kind_r, kind_nxt;
  logic [7:0]          value_r, value_nxt;
  logic [15:0]         count_r, count_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                last_r, last_nxt;

  epwf_pkg::step_t     cur_step;
  epwf_pkg::step_t     next_step;
  logic                done;
  logic                advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= epwf_pkg::STEP_WSTART;
      mid_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      mid_r   <= mid_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    value_r  <= value_nxt;
    count_r  <= count_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  always_comb begin
    cur_step   = mid_r ? step_r : head.first_step;
    advance    = !empty && (!valid_r || !out_stall);
    kind_nxt   = epwf_pkg::KIND_STATUS;
    value_nxt  = 8'd0;
    count_nxt  = 16'd0;
    status_nxt = epwf_pkg::STAT_OK;
    next_step  = epwf_pkg::STEP_BODY;
    done       = 1'b1;

    case (cur_step)
      epwf_pkg::STEP_WSTART: begin
        kind_nxt  = epwf_pkg::KIND_WSTART;
        value_nxt = {1'b0, head.dev};
        next_step = head.two_byte ? epwf_pkg::STEP_AHI : epwf_pkg::STEP_ALO;
        done      = 1'b0;
      end
      epwf_pkg::STEP_AHI: begin
        kind_nxt  = epwf_pkg::KIND_ADDR;
        value_nxt = head.mem[15:8];
        next_step = epwf_pkg::STEP_ALO;
        done      = 1'b0;
      end
      epwf_pkg::STEP_ALO: begin
        kind_nxt  = epwf_pkg::KIND_ADDR;
        value_nxt = head.mem[7:0];
        next_step = epwf_pkg::STEP_BODY;
        done      = 1'b0;
      end
      epwf_pkg::STEP_BODY: begin
        case (head.op)
          epwf_pkg::CMD_READ: begin
            kind_nxt  = epwf_pkg::KIND_RSTART;
            value_nxt = {1'b0, head.dev};
            count_nxt = head.count;
          end
          epwf_pkg::CMD_DATA: begin
            kind_nxt  = epwf_pkg::KIND_DATA;
            value_nxt = head.data;
            next_step = epwf_pkg::STEP_STOP;
            done      = !head.stop;
          end
          default: begin
            kind_nxt   = epwf_pkg::KIND_STATUS;
            status_nxt = head.status;
          end
        endcase
      end
      epwf_pkg::STEP_STOP: begin
        kind_nxt  = epwf_pkg::KIND_STOP;
        value_nxt = {1'b0, head.base};
      end
      default: ;
    endcase
    last_nxt = done;

    pop       = advance && done;
    valid_nxt = advance || (valid_r && out_stall);
    step_nxt  = step_r;
    mid_nxt   = mid_r;
    if (advance) begin
      step_nxt = next_step;
      mid_nxt  = !done;
    end
    if (!advance) begin
      kind_nxt   = kind_r;
      value_nxt  = value_r;
      count_nxt  = count_r;
      status_nxt = status_r;
      last_nxt   = last_r;
    end
  end

  assign out_valid       = valid_r;
  assign out_token_kind  = kind_r;
  assign out_token_value = value_r;
  assign out_read_count  = count_r;
  assign out_status      = status_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

[hdl/eeprom_page_write_framer.sv]
// The first token of an item passes through the command queue entry and then the output register.
// Throughput: one token per cycle while out_stall is low; an item occupies the token generator
// until it has sent all its tokens, one to five, through its single output register.
// A four-entry command queue lets input items be taken while tokens are still going out.
// Reset (synchronous, active low) sets part type 1 and device address 80, clears the
// write state and empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none
module eeprom_page_write_framer #(
  parameter int QUEUE_DEPTH = epwf_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_start_address,
  input  wire logic [15:0] in_length,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_token_kind,
  output logic [7:0]       out_token_value,
  output logic [15:0]      out_read_count,
  output logic [1:0]       out_status,
  output logic             out_last
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           empty;
  logic           full;
  epwf_pkg::cmd_t cmd;
  epwf_pkg::cmd_t head;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  epwf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .accept        (accept),
    .func          (in_func),
    .start_address (in_start_address),
    .length        (in_length),
    .data_byte     (in_data_byte),
    .push          (push),
    .cmd           (cmd)
  );

  epwf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  epwf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_token_value (out_token_value),
    .out_read_count  (out_read_count),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == epwf_pkg::KIND_STATUS) |-> out_last)
    else $error("status token not marked last");

  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_token_kind == epwf_pkg::KIND_STOP) ||
                  (out_token_kind == epwf_pkg::KIND_RSTART)) |-> out_last)
    else $error("stop or read start token not marked last");

  a_count_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind != epwf_pkg::KIND_RSTART) |-> (out_read_count == 16'd0))
    else $error("read count on a token other than read start");

  a_status_only_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != epwf_pkg::STAT_OK) |->
      (out_token_kind == epwf_pkg::KIND_STATUS))
    else $error("error code on a token other than status");

  a_addr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_token_kind == epwf_pkg::KIND_ADDR) ||
                  (out_token_kind == epwf_pkg::KIND_WSTART)) |-> !out_last)
    else $error("address phase token marked last");

endmodule
`default_nettype wire
